/* rtl/meb_pkg.sv */
package meb_pkg;

  localparam int FRAC_BITS = 60;
  localparam int MAX_DIM = 4096;

  localparam int DIM_W = 13;
  localparam int IDX_W = 12;
  localparam int ADDR_W = 26;
  localparam int ITER_W = 16;
  localparam int GRAY_W = 8;
  localparam int GNUM_W = ITER_W + GRAY_W;
  localparam int CFG_IDX_W = 3;

  localparam int DIV_STEPS = 64 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef logic signed [63:0] fix_t;
  typedef logic [63:0] mag_t;

  localparam fix_t FIX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fix_t FIX_MIN = 64'sh8000_0000_0000_0000;
  localparam mag_t MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam mag_t FX_ONE = 64'd1 << FRAC_BITS;
  localparam mag_t FX_TWO = 64'd2 << FRAC_BITS;
  localparam logic [GRAY_W-1:0] GRAY_SCALE = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_RE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_IM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZOOM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

  typedef struct packed {
    fix_t c_re;
    fix_t c_im;
    logic [ADDR_W-1:0] addr;
  } point_t;

  function automatic fix_t sat_add(fix_t a, fix_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? FIX_MIN : FIX_MAX;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  function automatic mag_t mag_of(fix_t a);
    mag_of = a[63] ? (64'd0 - mag_t'(a)) : mag_t'(a);
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] d);
    if (d == '0) begin
      eff_dim = DIM_W'(1);
    end else if (d > DIM_W'(MAX_DIM)) begin
      eff_dim = DIM_W'(MAX_DIM);
    end else begin
      eff_dim = d;
    end
  endfunction

endpackage

/* rtl/meb_div.sv */
module meb_div import meb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  mag_t dividend,
  input  mag_t divisor,
  output logic done,
  output mag_t quotient
);

  logic busy;
  logic [DIV_CNT_W-1:0] cnt;
  mag_t num;
  mag_t den;
  mag_t rem;
  mag_t quo;
  logic ovf;
  logic [64:0] trial;
  logic [64:0] diff;

  assign trial = {rem, num[63]};
  assign diff = trial - {1'b0, den};
  assign quotient = ovf ? MAG_MAX : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        num <= dividend;
        den <= divisor;
        rem <= '0;
        quo <= '0;
        ovf <= 1'b0;
      end else if (busy) begin
        num <= {num[62:0], 1'b0};
        if (quo[63:62] != 2'b00) begin
          ovf <= 1'b1;
        end
        if (!diff[64]) begin
          rem <= diff[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

/* rtl/meb_front.sv */
module meb_front import meb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [IDX_W-1:0] pixel_col,
  input  logic [IDX_W-1:0] pixel_row,
  input  fix_t center_re,
  input  fix_t center_im,
  input  mag_t zoom,
  input  logic [DIM_W-1:0] width_eff,
  input  logic [DIM_W-1:0] height_eff,
  output logic push,
  output point_t push_data,
  input  logic full
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_ADDR = 3'd1;
  localparam logic [2:0] F_ADDR2 = 3'd2;
  localparam logic [2:0] F_D1 = 3'd3;
  localparam logic [2:0] F_W1 = 3'd4;
  localparam logic [2:0] F_D2 = 3'd5;
  localparam logic [2:0] F_W2 = 3'd6;
  localparam logic [2:0] F_PUSH = 3'd7;

  logic [2:0] state;
  logic axis;
  logic [IDX_W-1:0] col;
  logic [IDX_W-1:0] row;
  logic [IDX_W+DIM_W-1:0] prod;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] addr_sum;
  fix_t c_re;
  fix_t c_im;
  logic tneg;
  mag_t tmag;
  fix_t t;
  fix_t cval;
  logic div_start;
  mag_t div_a;
  mag_t div_d;
  logic div_done;
  mag_t div_q;
  logic [IDX_W-1:0] idx;
  logic [DIM_W-1:0] dim;

  assign in_ready = (state == F_IDLE);
  assign idx = axis ? row : col;
  assign dim = axis ? height_eff : width_eff;
  assign div_start = (state == F_D1) || (state == F_D2);
  assign div_a = (state == F_D1) ? mag_t'({idx, 1'b0}) : tmag;
  assign div_d = (state == F_D1) ? mag_t'(dim) : zoom;
  assign t = fix_t'(div_q) - fix_t'(FX_ONE);
  assign cval = sat_add(tneg ? (fix_t'(0) - fix_t'(div_q)) : fix_t'(div_q),
                        axis ? center_im : center_re);
  assign addr_sum = ADDR_W'(prod) + ADDR_W'(col);
  assign push = (state == F_PUSH) && !full;
  assign push_data = '{c_re: c_re, c_im: c_im, addr: addr};

  meb_div u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_a),
    .divisor(div_d),
    .done(div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            col <= pixel_col;
            row <= pixel_row;
            state <= F_ADDR;
          end
        end
        F_ADDR: begin
          prod <= (IDX_W + DIM_W)'(row) * (IDX_W + DIM_W)'(width_eff);
          state <= F_ADDR2;
        end
        F_ADDR2: begin
          addr <= {addr_sum[ADDR_W-3:0], 2'b00};
          axis <= 1'b0;
          state <= F_D1;
        end
        F_D1: state <= F_W1;
        F_W1: begin
          if (div_done) begin
            tneg <= t[63];
            tmag <= mag_of(t);
            state <= F_D2;
          end
        end
        F_D2: state <= F_W2;
        F_W2: begin
          if (div_done) begin
            if (!axis) begin
              c_re <= cval;
              axis <= 1'b1;
              state <= F_D1;
            end else begin
              c_im <= cval;
              state <= F_PUSH;
            end
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/meb_fifo.sv */
module meb_fifo import meb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  point_t push_data,
  output logic full,
  input  logic pop,
  output point_t pop_data,
  output logic empty
);

  point_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/meb_mul.sv */
module meb_mul import meb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  mag_t a,
  input  mag_t b,
  output logic done,
  output mag_t result
);

  logic busy;
  logic [1:0] cnt;
  mag_t ra;
  mag_t rb;
  logic [127:0] acc;
  logic [31:0] ah;
  logic [31:0] bh;
  logic [63:0] part;
  logic [127:0] part_sh;
  mag_t res;

  assign ah = cnt[1] ? ra[63:32] : ra[31:0];
  assign bh = cnt[0] ? rb[63:32] : rb[31:0];
  assign part = 64'(ah) * 64'(bh);

  always_comb begin
    case (cnt)
      2'd0: part_sh = {64'd0, part};
      2'd3: part_sh = {part, 64'd0};
      default: part_sh = {32'd0, part, 32'd0};
    endcase
  end

  assign res = acc[FRAC_BITS+63:FRAC_BITS];
  assign result = ((acc[127:FRAC_BITS+64] != '0) || res[63]) ? MAG_MAX : res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 2'd0;
        ra <= a;
        rb <= b;
        acc <= '0;
      end else if (busy) begin
        acc <= acc + part_sh;
        cnt <= cnt + 1'b1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/meb_back.sv */
module meb_back import meb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  point_t pop_data,
  output logic pop,
  input  logic [ITER_W-1:0] iteration_limit,
  output logic out_valid,
  input  logic out_ready,
  output logic [ITER_W-1:0] escape_count,
  output logic [GRAY_W-1:0] gray_level,
  output logic [ADDR_W-1:0] byte_address
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_CHECK = 3'd1;
  localparam logic [2:0] B_MUL = 3'd2;
  localparam logic [2:0] B_MWAIT = 3'd3;
  localparam logic [2:0] B_UPD = 3'd4;
  localparam logic [2:0] B_UPD2 = 3'd5;
  localparam logic [2:0] B_GRAY = 3'd6;
  localparam logic [2:0] B_DONE = 3'd7;

  localparam int GCNT_W = $clog2(GNUM_W);

  logic [2:0] state;
  point_t pt;
  fix_t re;
  fix_t im;
  fix_t re2;
  fix_t im2;
  fix_t pm;
  fix_t dbl;
  fix_t dif;
  fix_t re_n;
  fix_t im_n;
  logic pneg;
  logic [ITER_W-1:0] iter;
  logic [1:0] msel;
  logic mul_start;
  mag_t mul_a;
  mag_t mul_b;
  logic mul_done;
  mag_t mul_r;
  logic [GNUM_W-1:0] gnum;
  logic [GNUM_W-1:0] gq;
  logic [ITER_W-1:0] grem;
  logic [GCNT_W-1:0] gcnt;
  logic [ITER_W:0] gtrial;
  logic [ITER_W:0] gdiff;
  logic out_free;

  assign pop = (state == B_IDLE) && !empty;
  assign mul_start = (state == B_MUL);
  assign mul_a = (msel == 2'd1) ? mag_of(im) : mag_of(re);
  assign mul_b = (msel == 2'd0) ? mag_of(re) : mag_of(im);
  assign re_n = sat_add(dif, pt.c_re);
  assign im_n = sat_add(dbl, pt.c_im);
  assign gtrial = {grem, gnum[GNUM_W-1]};
  assign gdiff = gtrial - {1'b0, iteration_limit};
  assign out_free = !out_valid || out_ready;

  meb_mul u_mul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(mul_a),
    .b(mul_b),
    .done(mul_done),
    .result(mul_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != B_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!empty) begin
            pt <= pop_data;
            re <= '0;
            im <= '0;
            iter <= '0;
            state <= B_CHECK;
          end
        end
        B_CHECK: begin
          if (iter < iteration_limit) begin
            msel <= 2'd0;
            pneg <= re[63] ^ im[63];
            state <= B_MUL;
          end else begin
            gnum <= GNUM_W'(iter) * GNUM_W'(GRAY_SCALE);
            gq <= '0;
            grem <= '0;
            gcnt <= '0;
            state <= (iteration_limit == '0) ? B_DONE : B_GRAY;
          end
        end
        B_MUL: state <= B_MWAIT;
        B_MWAIT: begin
          if (mul_done) begin
            case (msel)
              2'd0: re2 <= fix_t'(mul_r);
              2'd1: im2 <= fix_t'(mul_r);
              default: pm <= fix_t'(mul_r);
            endcase
            if (msel == 2'd2) begin
              state <= B_UPD;
            end else begin
              msel <= msel + 1'b1;
              state <= B_MUL;
            end
          end
        end
        B_UPD: begin
          dbl <= sat_add(pneg ? (fix_t'(0) - pm) : pm, pneg ? (fix_t'(0) - pm) : pm);
          dif <= sat_add(re2, fix_t'(0) - im2);
          state <= B_UPD2;
        end
        B_UPD2: begin
          re <= re_n;
          im <= im_n;
          if ((mag_of(re_n) > FX_TWO) || (mag_of(im_n) > FX_TWO)) begin
            gnum <= GNUM_W'(iter) * GNUM_W'(GRAY_SCALE);
            gq <= '0;
            grem <= '0;
            gcnt <= '0;
            state <= B_GRAY;
          end else begin
            iter <= iter + 1'b1;
            state <= B_CHECK;
          end
        end
        B_GRAY: begin
          gnum <= {gnum[GNUM_W-2:0], 1'b0};
          if (!gdiff[ITER_W]) begin
            grem <= gdiff[ITER_W-1:0];
            gq <= {gq[GNUM_W-2:0], 1'b1};
          end else begin
            grem <= gtrial[ITER_W-1:0];
            gq <= {gq[GNUM_W-2:0], 1'b0};
          end
          gcnt <= gcnt + 1'b1;
          if (gcnt == GCNT_W'(GNUM_W - 1)) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_free) begin
            escape_count <= iter;
            gray_level <= gq[GRAY_W-1:0];
            byte_address <= pt.addr;
            out_valid <= 1'b1;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* rtl/mandelbrot_escape_time_pixel.sv */
// Channel   Handshake              Payload
// in        in_valid / in_ready    pixel_col, pixel_row
// out       out_valid / out_ready  escape_count, gray_level, byte_address
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front takes a pixel beat and maps it to c with four bit-serial
// fixed-point divisions on one divider.
// The back forms two 64-bit squarings and a cross product per iteration,
// each of four 32x32 partial products on one multiplier, then divides for gray.
// A two-entry queue lets the front work on the next pixel during iteration.
// Reset is synchronous; a waiting result holds in the output register.
module mandelbrot_escape_time_pixel import meb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [IDX_W-1:0] pixel_col,
  input  logic [IDX_W-1:0] pixel_row,
  output logic out_valid,
  input  logic out_ready,
  output logic [ITER_W-1:0] escape_count,
  output logic [GRAY_W-1:0] gray_level,
  output logic [ADDR_W-1:0] byte_address,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  fix_t center_re;
  fix_t center_im;
  logic [62:0] zoom_factor;
  logic [ITER_W-1:0] iteration_limit;
  logic [DIM_W-1:0] img_width;
  logic [DIM_W-1:0] img_height;
  mag_t zoom;
  logic push;
  logic pop;
  logic full;
  logic empty;
  point_t push_data;
  point_t pop_data;

  assign cfg_ready = 1'b1;
  assign zoom = (zoom_factor == '0) ? 64'd1 : {1'b0, zoom_factor};

  always_ff @(posedge clk) begin
    if (rst) begin
      center_re <= '0;
      center_im <= '0;
      zoom_factor <= FX_ONE[62:0];
      iteration_limit <= 16'd256;
      img_width <= 13'd1024;
      img_height <= 13'd768;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_RE: center_re <= cfg_data;
        REG_CENTER_IM: center_im <= cfg_data;
        REG_ZOOM: zoom_factor <= cfg_data[62:0];
        REG_LIMIT: iteration_limit <= cfg_data[ITER_W-1:0];
        REG_WIDTH: img_width <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: img_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  meb_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_col(pixel_col),
    .pixel_row(pixel_row),
    .center_re(center_re),
    .center_im(center_im),
    .zoom(zoom),
    .width_eff(eff_dim(img_width)),
    .height_eff(eff_dim(img_height)),
    .push(push),
    .push_data(push_data),
    .full(full)
  );

  meb_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(full),
    .pop(pop),
    .pop_data(pop_data),
    .empty(empty)
  );

  meb_back u_back (
    .clk(clk),
    .rst(rst),
    .empty(empty),
    .pop_data(pop_data),
    .pop(pop),
    .iteration_limit(iteration_limit),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .escape_count(escape_count),
    .gray_level(gray_level),
    .byte_address(byte_address)
  );

endmodule
